// ===== hdl/oaat_pkg.sv =====
// Shared types, constants and hash helpers for the one-at-a-time hash block.
package oaat_pkg;

	localparam int unsigned HASH_W      = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BCOUNT_W    = 17;
	localparam int unsigned INDEX_W     = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [BCOUNT_W-1:0] BUCKET_RESET = BCOUNT_W'(1024);
	localparam logic [BCOUNT_W-1:0] BUCKET_LIMIT = BCOUNT_W'(65536);

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] c;
		a = h + HASH_W'(b);
		c = a + (a << 10);
		return c ^ (c >> 6);
	endfunction

	function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] b;
		a = h + (h << 3);
		b = a ^ (a >> 11);
		return b + (b << 15);
	endfunction

endpackage

// ===== hdl/oaat_if.sv =====
// Handshake channel interfaces: key bytes, hash results, configuration writes.
interface oaat_key_if;
	import oaat_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] key_byte;
	logic              last_byte;
	modport source(output valid, key_byte, last_byte, input ready);
	modport sink(input valid, key_byte, last_byte, output ready);
endinterface

interface oaat_result_if;
	import oaat_pkg::*;
	logic               valid;
	logic               ready;
	logic [HASH_W-1:0]  hash_value;
	logic [INDEX_W-1:0] bucket_index;
	modport source(output valid, hash_value, bucket_index, input ready);
	modport sink(input valid, hash_value, bucket_index, output ready);
endinterface

interface oaat_cfg_if;
	import oaat_pkg::*;
	logic                valid;
	logic                ready;
	logic [BCOUNT_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== hdl/oaat_front.sv =====
// Front end: takes key bytes, keeps the running hash, queues keys on their last byte.
module oaat_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [oaat_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last_byte,
	input  oaat_pkg::queue_status_t       q_status,
	output logic                          push,
	output logic [oaat_pkg::HASH_W-1:0]   push_data
);
	import oaat_pkg::*;

	logic [HASH_W-1:0] running_hash_q;
	logic              accept;

	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign push_data = mix_byte(running_hash_q, key_byte);
	assign push      = accept && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (accept) begin
			running_hash_q <= last_byte ? '0 : push_data;
		end
	end

endmodule

// ===== hdl/oaat_queue.sv =====
// Short FIFO of mixed hashes between front and back end.
module oaat_queue #(
	parameter int unsigned DEPTH = oaat_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [oaat_pkg::HASH_W-1:0] push_data,
	input  logic                        pop,
	output logic [oaat_pkg::HASH_W-1:0] pop_data,
	output oaat_pkg::queue_status_t     status
);
	import oaat_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [HASH_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/oaat_back.sv =====
// Back end: final mix, bit-serial modulo by the bucket count, output register.
module oaat_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  oaat_pkg::queue_status_t        q_status,
	input  logic [oaat_pkg::HASH_W-1:0]    q_data,
	output logic                           pop,
	input  logic [oaat_pkg::BCOUNT_W-1:0]  bucket_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [oaat_pkg::HASH_W-1:0]    hash_value,
	output logic [oaat_pkg::INDEX_W-1:0]   bucket_index
);
	import oaat_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int unsigned STEP_W = $clog2(HASH_W);

	logic [1:0]          state_q;
	logic [HASH_W-1:0]   hash_q;
	logic [HASH_W-1:0]   dividend_q;
	logic [BCOUNT_W-1:0] rem_q;
	logic [BCOUNT_W-1:0] div_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic [HASH_W-1:0]   out_hash_q;
	logic [INDEX_W-1:0]  out_index_q;

	logic [BCOUNT_W:0]   trial;
	logic                take;
	logic [BCOUNT_W-1:0] div_clamped;

	assign pop          = (state_q == ST_IDLE) && !q_status.empty;
	assign trial        = {rem_q, dividend_q[HASH_W-1]};
	assign take         = trial >= {1'b0, div_q};
	assign div_clamped  = (bucket_count > BUCKET_LIMIT) ? BUCKET_LIMIT : bucket_count;
	assign out_valid    = out_valid_q;
	assign hash_value   = out_hash_q;
	assign bucket_index = out_index_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				hash_q <= q_data;
			end
			ST_MIX: begin
				hash_q     <= final_mix(hash_q);
				dividend_q <= final_mix(hash_q);
				rem_q      <= '0;
				div_q      <= div_clamped;
			end
			ST_DIV: begin
				dividend_q <= dividend_q << 1;
				rem_q      <= take ? BCOUNT_W'(trial - {1'b0, div_q}) : BCOUNT_W'(trial);
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_hash_q  <= hash_q;
			out_index_q <= (div_q == '0) ? '0 : rem_q[INDEX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(HASH_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/one_at_a_time_hash_bucket.sv =====
// Top level: one-at-a-time hash of byte-streamed keys with bucket index.
//
// key_in takes one key byte per request, last_byte marks the end of a key.
// Non-final bytes are absorbed into the running hash and give no result.
// A final byte pushes the mixed hash into a short queue; the back end pops it,
// applies the final mix, then reduces it modulo the bucket count with a
// restoring divider, one dividend bit per cycle.
// The back end works on one key at a time and pops the next only after the
// output register has taken the last result.
// Bytes stream at one per cycle while the queue has room; key_in.ready drops
// only while the queue is full.
// result holds a registered request until taken; a stalled receiver stalls the
// divider at its finish, then the queue, then key_in.
// cfg writes bucket_count (always ready); write it only when idle. Values above
// 65536 act as 65536, zero gives bucket_index 0.
// Reset clears the running hash, empties the queue, drops result.valid and sets the
// bucket count to 1024.
module one_at_a_time_hash_bucket #(
	parameter int unsigned QUEUE_DEPTH = oaat_pkg::QUEUE_DEPTH
) (
	input logic          clk,
	input logic          arst_n,
	oaat_key_if.sink     key_in,
	oaat_result_if.source result,
	oaat_cfg_if.sink     cfg
);
	import oaat_pkg::*;

	logic [BCOUNT_W-1:0] bucket_count_q;
	queue_status_t       q_status;
	logic                push;
	logic [HASH_W-1:0]   push_data;
	logic                pop;
	logic [HASH_W-1:0]   pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			bucket_count_q <= cfg.data;
		end
	end

	oaat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_in.valid),
		.in_ready  (key_in.ready),
		.key_byte  (key_in.key_byte),
		.last_byte (key_in.last_byte),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	oaat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	oaat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_data       (pop_data),
		.pop          (pop),
		.bucket_count (bucket_count_q),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.hash_value   (result.hash_value),
		.bucket_index (result.bucket_index)
	);

`ifndef NO_ASSERTIONS
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty at once");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full))
		else $error("key pushed into a full queue");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(key_in.valid && key_in.ready && key_in.last_byte) |=> !q_status.empty)
		else $error("final key byte did not reach the queue");
`endif

endmodule

// ===== tb/one_at_a_time_hash_bucket_tb.sv =====
// Testbench for one_at_a_time_hash_bucket: directed table, then random keys checked by a predictor.
module one_at_a_time_hash_bucket_tb;
	import oaat_pkg::*;

	typedef enum logic [1:0] {CHK_PREDICT, CHK_INDEX, CHK_FULL} row_chk_t;

	typedef struct packed {
		logic                set_cfg;
		logic [BCOUNT_W-1:0] cfg_val;
		logic [BYTE_W-1:0]   kb;
		logic                lb;
		row_chk_t            chk;
		logic [HASH_W-1:0]   hash;
		logic [INDEX_W-1:0]  idx;
	} key_row_t;

	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [INDEX_W-1:0] idx;
	} hash_result_t;

	localparam int N_ROWS = 18;
	localparam int DRAIN_CYCLES = 40;

	localparam key_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{1'b0, 17'd0,      8'h00, 1'b1, CHK_FULL,    32'h0, 16'h0},
		'{1'b0, 17'd0,      8'hFF, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'h80, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'h01, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'hFF, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		// zero bucket count
		'{1'b1, 17'd0,      8'hA5, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'h5A, 1'b1, CHK_INDEX,   32'h0, 16'h0},
		'{1'b1, 17'd1,      8'hFF, 1'b1, CHK_INDEX,   32'h0, 16'h0},
		'{1'b1, 17'd65536,  8'hFF, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'hFF, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'hFF, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		// oversized bucket count, clamps to 65536
		'{1'b1, 17'h1FFFF,  8'h80, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'h7F, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b1, 17'd65537,  8'h00, 1'b0, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b0, 17'd0,      8'h00, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b1, 17'd2,      8'h55, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b1, 17'd3,      8'hAA, 1'b1, CHK_PREDICT, 32'h0, 16'h0},
		'{1'b1, 17'd1024,   8'h00, 1'b1, CHK_FULL,    32'h0, 16'h0}
	};

	logic clk;
	logic arst_n;

	oaat_key_if    key_ch();
	oaat_result_if res_ch();
	oaat_cfg_if    cfg_ch();

	one_at_a_time_hash_bucket u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	logic [HASH_W-1:0]   running_hash_q;
	logic [BCOUNT_W-1:0] bucket_count_q;
	hash_result_t        hash_expect [$];
	logic                no_idle;
	int                  error_count;
	int                  keys_sent;
	int                  results_seen;
	int                  settings_used;

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [HASH_W-1:0] absorb_byte(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] t;
		t = h + {24'b0, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

	function automatic logic [INDEX_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
		input logic [BCOUNT_W-1:0] cnt);
		logic [HASH_W-1:0] d;
		d = (cnt > 17'd65536) ? 32'd65536 : {15'b0, cnt};
		if (d == 0)
			return '0;
		return INDEX_W'(h % d);
	endfunction

	task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
		input logic [HASH_W-1:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic record_key(input logic [BYTE_W-1:0] b, input logic l, input row_chk_t chk,
		input logic [HASH_W-1:0] th, input logic [INDEX_W-1:0] ti);
		logic [HASH_W-1:0] fin;
		hash_result_t      e;
		keys_sent++;
		running_hash_q = absorb_byte(running_hash_q, b);
		if (l) begin
			fin = finish_hash(running_hash_q);
			running_hash_q = '0;
			e.hash = (chk == CHK_FULL) ? th : fin;
			e.idx  = (chk == CHK_PREDICT) ? bucket_of(fin, bucket_count_q) : ti;
			hash_expect.push_back(e);
		end
	endtask

	task automatic push_key(input logic [BYTE_W-1:0] b, input logic l, input row_chk_t chk,
		input logic [HASH_W-1:0] th, input logic [INDEX_W-1:0] ti);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk) key_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		key_ch.valid     <= 1'b1;
		key_ch.key_byte  <= b;
		key_ch.last_byte <= l;
		do @(posedge clk); while (!key_ch.ready);
		record_key(b, l, chk, th, ti);
	endtask

	task automatic wait_idle();
		@(negedge clk) key_ch.valid <= 1'b0;
		while (hash_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_buckets(input logic [BCOUNT_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		bucket_count_q = val;
		settings_used++;
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	// result-side backpressure
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				@(negedge clk) res_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	always @(posedge clk) begin
		hash_result_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (hash_expect.size() == 0) begin
				report_mismatch("unexpected result hash", res_ch.hash_value, '0);
			end else begin
				e = hash_expect.pop_front();
				if (res_ch.hash_value !== e.hash)
					report_mismatch("hash_value", res_ch.hash_value, e.hash);
				if (res_ch.bucket_index !== e.idx)
					report_mismatch("bucket_index", {16'b0, res_ch.bucket_index}, {16'b0, e.idx});
			end
		end
	end

	initial begin
		#4000000;
		$display("timeout, %0d requests pending", hash_expect.size());
		$display("one_at_a_time_hash_bucket_tb failed");
		$finish;
	end

	initial begin
		int                  p;
		int                  k;
		int                  len;
		int                  phase_sent;
		logic [BCOUNT_W-1:0] cnt;
		arst_n           = 1'b0;
		key_ch.valid     = 1'b0;
		key_ch.key_byte  = '0;
		key_ch.last_byte = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		no_idle          = 1'b0;
		error_count      = 0;
		keys_sent        = 0;
		results_seen     = 0;
		settings_used    = 0;
		running_hash_q   = '0;
		bucket_count_q   = BUCKET_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++) begin
			if (DIRECTED_ROWS[r].set_cfg) begin
				wait_idle();
				write_buckets(DIRECTED_ROWS[r].cfg_val);
			end
			push_key(DIRECTED_ROWS[r].kb, DIRECTED_ROWS[r].lb, DIRECTED_ROWS[r].chk,
				DIRECTED_ROWS[r].hash, DIRECTED_ROWS[r].idx);
		end

		for (p = 0; p < 10; p++) begin
			wait_idle();
			case (p)
				0: cnt = 17'd1000;
				1: cnt = 17'd65536;
				2: cnt = 17'd1;
				3: cnt = 17'd0;
				4: cnt = 17'h1FFFF;
				5: cnt = BCOUNT_W'($urandom_range(1, 65536));
				6: cnt = BCOUNT_W'($urandom_range(0, 131071));
				7: cnt = 17'd97;
				8: cnt = BCOUNT_W'($urandom_range(2, 300));
				default: cnt = 17'd1024;
			endcase
			write_buckets(cnt);
			no_idle = (p % 3 == 1);
			phase_sent = 0;
			while (phase_sent < 130) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					push_key(BYTE_W'($urandom_range(0, 255)), k == len - 1, CHK_PREDICT, '0, '0);
				phase_sent += len;
			end
		end
		no_idle = 1'b0;

		@(negedge clk) key_ch.valid <= 1'b0;
		while (hash_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d key bytes, %0d hashes checked, %0d bucket count settings",
			keys_sent, results_seen, settings_used);
		if (error_count == 0 && hash_expect.size() == 0) begin
			$display("one_at_a_time_hash_bucket_tb passed");
		end else begin
			$display("%0d mismatches, %0d requests left", error_count, hash_expect.size());
			$display("one_at_a_time_hash_bucket_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/oaat_pkg.sv
hdl/oaat_if.sv
hdl/oaat_front.sv
hdl/oaat_queue.sv
hdl/oaat_back.sv
hdl/one_at_a_time_hash_bucket.sv
tb/one_at_a_time_hash_bucket_tb.sv
